// ===== hw/rtl/dmsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsa_pkg
// Types, field widths, defaults and sequencer states shared by the dual
// mean / standard deviation accumulator.
// ----------------------------------------------------------------------------
package dmsa_pkg;

	localparam int IN_W  = 16;  // input count field width
	localparam int OUT_W = 24;  // mean and std field width
	localparam int CNT_W = 11;  // item count field width

	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef struct packed {
		logic [IN_W-1:0] predator_count;
		logic [IN_W-1:0] prey_count;
		logic            last;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] mean_predators;
		logic [OUT_W-1:0] mean_prey;
		logic [OUT_W-1:0] sd_predators;
		logic [OUT_W-1:0] sd_prey;
		logic [CNT_W-1:0] item_count;
		logic             overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NQ,
		ST_MUL_SS,
		ST_SQRT,
		ST_DIV_STD,
		ST_DIV_MEAN,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_status_t;

endpackage

// ===== hw/rtl/dmsa_alu.sv =====
// ----------------------------------------------------------------------------
// dmsa_alu
// Shared add/subtract unit; the carry out doubles as the borrow of a
// subtraction, so it also serves as the compare.
// ----------------------------------------------------------------------------
module dmsa_alu #(
	parameter int AW = 32
) (
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	input  logic          sub,
	output logic [AW-1:0] res,
	output logic          cout
);
	logic [AW:0] full;

	always_comb begin
		if (sub) begin
			full = {1'b0, a} - {1'b0, b};
		end else begin
			full = {1'b0, a} + {1'b0, b};
		end
	end

	assign res  = full[AW-1:0];
	assign cout = full[AW];

endmodule

// ===== hw/rtl/dmsa_accum.sv =====
// ----------------------------------------------------------------------------
// dmsa_accum
// Item counter, per-channel sums and sums of squares, plus the lost-item
// flag. One item is folded in per accepted transaction below MAX_ITEMS.
// ----------------------------------------------------------------------------
module dmsa_accum #(
	parameter int MAX_ITEMS = 1024,
	parameter int CW        = 16,
	parameter int NB        = 11,
	parameter int SW        = 27,
	parameter int QW        = 43
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          clr,
	input  logic [CW-1:0] a,
	input  logic [CW-1:0] b,
	output logic [NB-1:0] n,
	output logic [SW-1:0] sum_first,
	output logic [SW-1:0] sum_second,
	output logic [QW-1:0] sq_first,
	output logic [QW-1:0] sq_second,
	output logic          lost
);
	logic [NB-1:0]   cnt_q;
	logic [SW-1:0]   sum_a_q, sum_b_q;
	logic [QW-1:0]   sq_a_q, sq_b_q;
	logic            lost_q;
	logic            full;
	logic [2*CW-1:0] a_sq, b_sq;

	assign full = (cnt_q == NB'(MAX_ITEMS));
	assign a_sq = a * a;
	assign b_sq = b * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
			lost_q  <= 1'b0;
		end else if (clr) begin
			cnt_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
			lost_q  <= 1'b0;
		end else if (en) begin
			if (full) begin
				// drop the item, remember it
				lost_q <= 1'b1;
			end else begin
				cnt_q   <= cnt_q + 1'b1;
				sum_a_q <= sum_a_q + SW'(a);
				sum_b_q <= sum_b_q + SW'(b);
				sq_a_q  <= sq_a_q + QW'(a_sq);
				sq_b_q  <= sq_b_q + QW'(b_sq);
			end
		end
	end

	assign n          = cnt_q;
	assign sum_first  = sum_a_q;
	assign sum_second = sum_b_q;
	assign sq_first   = sq_a_q;
	assign sq_second  = sq_b_q;
	assign lost       = lost_q;

endmodule

// ===== hw/rtl/dmsa_engine.sv =====
// ----------------------------------------------------------------------------
// dmsa_engine
// Sequencer around one shared adder. Per channel it forms n*Q - S*S by
// shift-and-add, takes the bit-pair square root of that value scaled by
// 4^FRAC, then divides the root and S*2^FRAC by n, one bit per cycle.
// ----------------------------------------------------------------------------
module dmsa_engine #(
	parameter int NB   = 11,
	parameter int SW   = 27,
	parameter int QW   = 43,
	parameter int FRAC = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        out_free,
	input  logic [NB-1:0]               n,
	input  logic [SW-1:0]               sum_first,
	input  logic [SW-1:0]               sum_second,
	input  logic [QW-1:0]               sq_first,
	input  logic [QW-1:0]               sq_second,
	output dmsa_pkg::eng_status_t       status,
	output logic [dmsa_pkg::OUT_W-1:0]  mean_first,
	output logic [dmsa_pkg::OUT_W-1:0]  mean_second,
	output logic [dmsa_pkg::OUT_W-1:0]  std_first,
	output logic [dmsa_pkg::OUT_W-1:0]  std_second
);
	import dmsa_pkg::*;

	localparam int VW  = 2 * SW;             // n*Q and S*S both fit here
	localparam int K   = SW + FRAC;          // root and quotient width
	localparam int RW  = K + 2;              // partial remainder width
	localparam int AW  = (VW > RW) ? VW : RW;
	localparam int SCW = $clog2(K);

	eng_state_t       state_q, state_d;
	logic             ch_q, ch_d;
	logic [SCW-1:0]   step_q, step_d;
	logic [VW-1:0]    acc_q, acc_d;
	logic [VW-1:0]    op_q, op_d;
	logic [SW-1:0]    mb_q, mb_d;
	logic [RW-1:0]    rem_q, rem_d;
	logic [K-1:0]     root_q, root_d;
	logic [OUT_W-1:0] mean_q [2];
	logic [OUT_W-1:0] std_q [2];

	logic             last_step;
	logic             save_std, save_mean;
	logic [SW-1:0]    s_sel;
	logic [RW-1:0]    sq_rem, sq_trial, dv_rem;
	logic [K-1:0]     quo_next;
	logic [AW-1:0]    alu_a, alu_b, alu_res;
	logic             alu_sub, alu_cout;

	assign last_step = (step_q == '0);
	assign s_sel     = ch_q ? sum_second : sum_first;
	assign sq_rem    = {rem_q[RW-3:0], acc_q[VW-1 -: 2]};
	assign sq_trial  = {root_q, 2'b01};
	assign dv_rem    = {rem_q[RW-2:0], root_q[K-1]};
	assign quo_next  = {root_q[K-2:0], ~alu_cout};

	dmsa_alu #(
		.AW(AW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res),
		.cout(alu_cout)
	);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			ST_MUL_NQ: begin
				alu_a   = AW'(acc_q);
				alu_b   = mb_q[0] ? AW'(op_q) : '0;
				alu_sub = 1'b0;
			end
			ST_MUL_SS: begin
				alu_a = AW'(acc_q);
				alu_b = mb_q[0] ? AW'(op_q) : '0;
			end
			ST_SQRT: begin
				alu_a = AW'(sq_rem);
				alu_b = AW'(sq_trial);
			end
			ST_DIV_STD, ST_DIV_MEAN: begin
				alu_a = AW'(dv_rem);
				alu_b = AW'(n);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_MUL_NQ;
			ST_MUL_NQ:   if (last_step) state_d = ST_MUL_SS;
			ST_MUL_SS:   if (last_step) state_d = ST_SQRT;
			ST_SQRT:     if (last_step) state_d = ST_DIV_STD;
			ST_DIV_STD:  if (last_step) state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: if (last_step) state_d = ch_q ? ST_DONE : ST_MUL_NQ;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		status.busy = (state_q != ST_IDLE);
		status.done = (state_q == ST_DONE);
	end

	// datapath
	always_comb begin
		acc_d     = acc_q;
		op_d      = op_q;
		mb_d      = mb_q;
		rem_d     = rem_q;
		root_d    = root_q;
		step_d    = step_q;
		ch_d      = ch_q;
		save_std  = 1'b0;
		save_mean = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ch_d   = 1'b0;
					acc_d  = '0;
					op_d   = VW'(sq_first);
					mb_d   = SW'(n);
					step_d = SCW'(NB - 1);
				end
			end
			ST_MUL_NQ: begin
				acc_d  = alu_res[VW-1:0];
				op_d   = {op_q[VW-2:0], 1'b0};
				mb_d   = mb_q >> 1;
				step_d = step_q - 1'b1;
				if (last_step) begin
					op_d   = VW'(s_sel);
					mb_d   = s_sel;
					step_d = SCW'(SW - 1);
				end
			end
			ST_MUL_SS: begin
				acc_d  = alu_res[VW-1:0];
				op_d   = {op_q[VW-2:0], 1'b0};
				mb_d   = mb_q >> 1;
				step_d = step_q - 1'b1;
				if (last_step) begin
					rem_d  = '0;
					root_d = '0;
					step_d = SCW'(K - 1);
				end
			end
			ST_SQRT: begin
				// two radicand bits per step; zeros shift in for the fraction
				acc_d  = {acc_q[VW-3:0], 2'b00};
				root_d = quo_next;
				rem_d  = alu_cout ? sq_rem : alu_res[RW-1:0];
				step_d = step_q - 1'b1;
				if (last_step) begin
					rem_d  = '0;
					step_d = SCW'(K - 1);
				end
			end
			ST_DIV_STD: begin
				root_d = quo_next;
				rem_d  = alu_cout ? dv_rem : alu_res[RW-1:0];
				step_d = step_q - 1'b1;
				if (last_step) begin
					save_std = 1'b1;
					root_d   = K'(s_sel) << FRAC;
					rem_d    = '0;
					step_d   = SCW'(K - 1);
				end
			end
			ST_DIV_MEAN: begin
				root_d = quo_next;
				rem_d  = alu_cout ? dv_rem : alu_res[RW-1:0];
				step_d = step_q - 1'b1;
				if (last_step) begin
					save_mean = 1'b1;
					if (!ch_q) begin
						ch_d   = 1'b1;
						acc_d  = '0;
						op_d   = VW'(sq_second);
						mb_d   = SW'(n);
						step_d = SCW'(NB - 1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		op_q   <= op_d;
		mb_q   <= mb_d;
		rem_q  <= rem_d;
		root_q <= root_d;
		if (save_std) begin
			std_q[ch_q] <= OUT_W'(quo_next);
		end
		if (save_mean) begin
			mean_q[ch_q] <= OUT_W'(quo_next);
		end
	end

	assign mean_first  = mean_q[0];
	assign mean_second = mean_q[1];
	assign std_first   = std_q[0];
	assign std_second  = std_q[1];

endmodule

// ===== hw/rtl/dual_mean_std_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// dual_mean_std_accumulator_core
// Population mean and standard deviation of two count channels over a run
// of items, in unsigned fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall / item) carries one pair of
//   counts per transaction. Items that are not marked last are summed as
//   they are accepted; the block takes one per cycle while item_stall is
//   low. Items past MAX_ITEMS are dropped and flagged in the result.
//   An item marked last is summed too, then the shared-adder sequencer runs
//   both channels: per channel n*Q, then S*S, then the square root, the
//   std divide and the mean divide. item_stall stays high meanwhile.
//   The result channel (result_valid / result_stall / result) is registered:
//   while result_stall holds a result, new items keep being summed, and a
//   finished result waits inside the sequencer until the register frees.
//   The sums clear when the result enters the output register.
//   Reset clears the sums, the sequencer and result_valid, not the result data.
// ----------------------------------------------------------------------------
module dual_mean_std_accumulator_core #(
	parameter int MAX_ITEMS  = dmsa_pkg::MAX_ITEMS_DEF,
	parameter int COUNT_BITS = dmsa_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = dmsa_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dmsa_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dmsa_pkg::result_t result
);
	import dmsa_pkg::*;

	localparam int CW = (COUNT_BITS < IN_W) ? COUNT_BITS : IN_W;
	localparam int NB = $clog2(MAX_ITEMS + 1);
	localparam int SW = CW + NB;
	localparam int QW = 2 * CW + NB;

	logic             item_acc;
	logic             start_q;
	logic             out_free;
	logic             load_res;
	logic             result_valid_q;
	result_t          result_q;
	eng_status_t      status;

	logic [NB-1:0]    n;
	logic [SW-1:0]    sum_first, sum_second;
	logic [QW-1:0]    sq_first, sq_second;
	logic             lost;
	logic [OUT_W-1:0] mean_first, mean_second, std_first, std_second;

	assign item_stall = start_q | status.busy;
	assign item_acc   = item_valid & ~item_stall;
	assign out_free   = ~result_valid_q | ~result_stall;
	assign load_res   = status.done & out_free;

	dmsa_accum #(
		.MAX_ITEMS(MAX_ITEMS),
		.CW       (CW),
		.NB       (NB),
		.SW       (SW),
		.QW       (QW)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (item_acc),
		.clr       (load_res),
		.a         (item.predator_count[CW-1:0]),
		.b         (item.prey_count[CW-1:0]),
		.n         (n),
		.sum_first (sum_first),
		.sum_second(sum_second),
		.sq_first  (sq_first),
		.sq_second (sq_second),
		.lost      (lost)
	);

	dmsa_engine #(
		.NB  (NB),
		.SW  (SW),
		.QW  (QW),
		.FRAC(FRAC_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start_q),
		.out_free   (out_free),
		.n          (n),
		.sum_first  (sum_first),
		.sum_second (sum_second),
		.sq_first   (sq_first),
		.sq_second  (sq_second),
		.status     (status),
		.mean_first (mean_first),
		.mean_second(mean_second),
		.std_first  (std_first),
		.std_second (std_second)
	);

	// start in the cycle after the last item is accepted, so the sums include it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			start_q <= item_acc & item.last;
			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			result_q.mean_predators <= mean_first;
			result_q.mean_prey      <= mean_second;
			result_q.sd_predators   <= std_first;
			result_q.sd_prey        <= std_second;
			result_q.item_count     <= CNT_W'(n);
			result_q.overflow       <= lost;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
